[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define CGR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on clk, off while rst_n is low.
`define CGR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[hw/rtl/cgr_pkg.sv]
`timescale 1ns / 1ps

package cgr_pkg;

  localparam int MAX_STOPS  = 16;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 5;
  localparam int POS_W      = 16;
  localparam int CH_W       = 8;
  localparam int COL_W      = 4 * CH_W;
  localparam int NUM_W      = 24;
  localparam int DIV_STEPS  = 8;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  localparam logic [POS_W-1:0] FULL_SCALE = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_ADD     = 2'd0,
    MODE_REMOVE  = 2'd1,
    MODE_REVERSE = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_BAD_SLOT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOOP,
    S_MUL,
    S_SUM,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             capture;
    logic             add_wr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             clr_track;
    logic             total_dec;
    logic             mul;
    logic             sum;
    logic             div_step;
    logic [2:0]       div_sh;
    logic             res_load;
  } cgr_cmd_t;

  typedef struct packed {
    mode_t            mode;
    logic             err;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] total;
  } cgr_stat_t;

  // Table contents after reset: black at 0 in slot 0, white at full scale in slot 1.
  function automatic logic [POS_W-1:0] reset_pos(input logic [IDX_W-1:0] addr);
    reset_pos = (addr == IDX_W'(1)) ? FULL_SCALE : '0;
  endfunction

  function automatic logic [COL_W-1:0] reset_col(input logic [IDX_W-1:0] addr);
    reset_col = (addr == IDX_W'(1)) ? '1 : '0;
  endfunction

endpackage

[hw/rtl/cgr_ctrl.sv]
`timescale 1ns / 1ps

module cgr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  cgr_pkg::cgr_stat_t stat,
  output cgr_pkg::cgr_cmd_t  cmd
);
  import cgr_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             more;
  logic             slot_free;

  assign more      = (k_r < stat.total);
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (stat.err) begin
          state_nxt = S_DONE;
        end else begin
          case (stat.mode)
            MODE_ADD: state_nxt = S_DONE;
            MODE_REMOVE: begin
              k_nxt     = CNT_W'(stat.slot) + CNT_W'(1);
              state_nxt = S_LOOP;
            end
            default: begin
              k_nxt     = '0;
              state_nxt = S_LOOP;
            end
          endcase
        end
      end
      S_LOOP: begin
        if (more) begin
          k_nxt = k_r + CNT_W'(1);
        end else if (stat.mode == MODE_QUERY) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MUL: state_nxt = S_SUM;
      S_SUM: begin
        k_nxt     = CNT_W'(DIV_STEPS - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (k_r == '0) state_nxt = S_DONE;
        else k_nxt = k_r - CNT_W'(1);
      end
      S_DONE: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_tready     = (state_r == S_IDLE);
    cmd.capture   = (state_r == S_IDLE) && in_tvalid;
    cmd.add_wr    = (state_r == S_DISPATCH) && !stat.err && (stat.mode == MODE_ADD);
    cmd.clr_track = (state_r == S_DISPATCH);
    cmd.rd_en     = (state_r == S_LOOP) && more;
    cmd.rd_addr   = k_r[IDX_W-1:0];
    cmd.total_dec = (state_r == S_LOOP) && !more && (stat.mode == MODE_REMOVE);
    cmd.mul       = (state_r == S_MUL);
    cmd.sum       = (state_r == S_SUM);
    cmd.div_step  = (state_r == S_DIV);
    cmd.div_sh    = k_r[2:0];
    cmd.res_load  = (state_r == S_DONE) && slot_free;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/cgr_dp.sv]
`timescale 1ns / 1ps

module cgr_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [cgr_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic [1:0]                      in_tuser,
  input  cgr_pkg::cgr_cmd_t               cmd,
  output cgr_pkg::cgr_stat_t              stat,
  output logic [cgr_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import cgr_pkg::*;

  // stop table
  logic [POS_W-1:0] pos_mem [MAX_STOPS];
  logic [COL_W-1:0] col_mem [MAX_STOPS];
  logic [MAX_STOPS-1:0] valid_r;
  logic [CNT_W-1:0] total_r;

  // captured item
  mode_t            mode_r;
  logic [POS_W-1:0] pos_in_r;
  logic [COL_W-1:0] col_in_r;
  logic [IDX_W-1:0] slot_r;
  logic [POS_W-1:0] q_r;
  status_t          status_r;

  // read port
  logic [POS_W-1:0] rd_pos_r;
  logic [COL_W-1:0] rd_col_r;
  logic [IDX_W-1:0] rd_tag_r;
  logic             rd_vld_r;

  // bracketing stops
  logic             has_lo_r, has_hi_r;
  logic [POS_W-1:0] lo_pos_r, hi_pos_r;
  logic [COL_W-1:0] lo_col_r, hi_col_r;

  // interpolation lanes
  logic [NUM_W-1:0] m0_r  [4];
  logic [NUM_W-1:0] m1_r  [4];
  logic [NUM_W-1:0] rem_r [4];
  logic [CH_W-1:0]  quo_r [4];

  logic [OUT_DATA_W-1:0] out_r;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [POS_W-1:0] wr_pos;
  logic [COL_W-1:0] wr_col;
  logic [POS_W-1:0] d_w, t_w, dmt_w;
  logic [NUM_W-1:0] dsh_w;
  logic [COL_W-1:0] res_col;
  status_t          status_nxt;
  mode_t            in_mode;

  assign in_mode = mode_t'(in_tuser);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = total_r[IDX_W-1:0];
    wr_pos  = pos_in_r;
    wr_col  = col_in_r;
    if (cmd.add_wr) begin
      wr_en = 1'b1;
    end else if (rd_vld_r && (mode_r == MODE_REVERSE)) begin
      wr_en   = 1'b1;
      wr_addr = rd_tag_r;
      wr_pos  = FULL_SCALE - rd_pos_r;
      wr_col  = rd_col_r;
    end else if (rd_vld_r && (mode_r == MODE_REMOVE)) begin
      // compaction: entry k+1 moves down to k
      wr_en   = 1'b1;
      wr_addr = rd_tag_r - IDX_W'(1);
      wr_pos  = rd_pos_r;
      wr_col  = rd_col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pos_mem[wr_addr] <= wr_pos;
      col_mem[wr_addr] <= wr_col;
    end
    if (cmd.rd_en) begin
      rd_pos_r <= valid_r[cmd.rd_addr] ? pos_mem[cmd.rd_addr] : reset_pos(cmd.rd_addr);
      rd_col_r <= valid_r[cmd.rd_addr] ? col_mem[cmd.rd_addr] : reset_col(cmd.rd_addr);
      rd_tag_r <= cmd.rd_addr;
    end
  end

  always_comb begin
    status_nxt = STATUS_OK;
    if ((in_mode == MODE_ADD) && (total_r >= CNT_W'(MAX_STOPS))) status_nxt = STATUS_FULL;
    else if ((in_mode == MODE_REMOVE) && (CNT_W'(in_tdata[51:48]) >= total_r))
      status_nxt = STATUS_BAD_SLOT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      total_r  <= CNT_W'(2);
      rd_vld_r <= 1'b0;
      has_lo_r <= 1'b0;
      has_hi_r <= 1'b0;
      mode_r   <= MODE_ADD;
      status_r <= STATUS_OK;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (wr_en) valid_r[wr_addr] <= 1'b1;
      if (cmd.add_wr) total_r <= total_r + CNT_W'(1);
      else if (cmd.total_dec) total_r <= total_r - CNT_W'(1);
      if (cmd.capture) begin
        mode_r   <= in_mode;
        status_r <= status_nxt;
      end
      if (cmd.clr_track) begin
        has_lo_r <= 1'b0;
        has_hi_r <= 1'b0;
      end else if (rd_vld_r && (mode_r == MODE_QUERY)) begin
        // strict compares keep the earliest slot on ties
        if (rd_pos_r < q_r) begin
          if (!has_lo_r || (lo_pos_r < rd_pos_r)) has_lo_r <= 1'b1;
        end else begin
          if (!has_hi_r || (hi_pos_r > rd_pos_r)) has_hi_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_in_r <= in_tdata[15:0];
      col_in_r <= in_tdata[47:16];
      slot_r   <= in_tdata[51:48];
      // i/255 of full scale is exactly i*257
      q_r      <= {in_tdata[59:52], in_tdata[59:52]};
    end
    if (rd_vld_r && (mode_r == MODE_QUERY)) begin
      if (rd_pos_r < q_r) begin
        if (!has_lo_r || (lo_pos_r < rd_pos_r)) begin
          lo_pos_r <= rd_pos_r;
          lo_col_r <= rd_col_r;
        end
      end else begin
        if (!has_hi_r || (hi_pos_r > rd_pos_r)) begin
          hi_pos_r <= rd_pos_r;
          hi_col_r <= rd_col_r;
        end
      end
    end
  end

  assign d_w   = hi_pos_r - lo_pos_r;
  assign t_w   = q_r - lo_pos_r;
  assign dmt_w = d_w - t_w;
  assign dsh_w = NUM_W'(d_w) << cmd.div_sh;

  // per channel: (c0*(d-t) + c1*t + d/2) / d, quotient fits 8 bits
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 4; ch++) begin
      if (cmd.mul) begin
        m0_r[ch] <= NUM_W'(lo_col_r[ch*CH_W +: CH_W]) * NUM_W'(dmt_w);
        m1_r[ch] <= NUM_W'(hi_col_r[ch*CH_W +: CH_W]) * NUM_W'(t_w);
      end
      if (cmd.sum) begin
        rem_r[ch] <= m0_r[ch] + m1_r[ch] + NUM_W'(d_w >> 1);
        quo_r[ch] <= '0;
      end else if (cmd.div_step) begin
        if (rem_r[ch] >= dsh_w) begin
          rem_r[ch] <= rem_r[ch] - dsh_w;
          quo_r[ch] <= {quo_r[ch][CH_W-2:0], 1'b1};
        end else begin
          quo_r[ch] <= {quo_r[ch][CH_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    res_col = '0;
    if (mode_r == MODE_QUERY) begin
      if (has_lo_r && has_hi_r) res_col = {quo_r[3], quo_r[2], quo_r[1], quo_r[0]};
      else if (has_lo_r) res_col = lo_col_r;
      else if (has_hi_r) res_col = hi_col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_r <= {1'b0, total_r, status_r, res_col};
    end
  end

  assign out_tdata  = out_r;
  assign stat.mode  = mode_r;
  assign stat.err   = (status_r != STATUS_OK);
  assign stat.slot  = slot_r;
  assign stat.total = total_r;

endmodule

[hw/rtl/color_gradient_ramp_top.sv]
`timescale 1ns / 1ps

// Multi-stop RGBA gradient with up to 16 stops held in insertion order; after
// reset it holds black at 0 and white at full scale. The tuser mode selects
// add, remove, reverse or query; every transaction returns exactly one result
// with status and the stop count. One transaction is processed at a time while
// the previous result may still sit in the output register. Reverse scans
// the whole table and remove scans the stops above the removed slot, one
// table read per cycle; a query scans the whole table through its single read
// port, then runs one multiply stage, one sum stage and an 8-step restoring
// divide that runs on all four channels at once. The input is accepted again
// in the cycle after the result is loaded.
module color_gradient_ramp_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mark_position[15:0], red_in[23:16], green_in[31:24], blue_in[39:32],
  // alpha_in[47:40], slot[51:48], query_index[59:52], zero pad
  input  logic [63:0] in_tdata,
  // mode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // red_out[7:0], green_out[15:8], blue_out[23:16], alpha_out[31:24],
  // status[33:32], stop_count[38:34], zero pad
  output logic [39:0] out_tdata
);
  import cgr_pkg::*;

  cgr_cmd_t  cmd;
  cgr_stat_t stat;

  cgr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  cgr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata)
  );

`include "assert_macros.svh"

  `CGR_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready)
  `CGR_ASSERT_IMP(a_full_count, out_tvalid && (out_tdata[33:32] == STATUS_FULL), out_tdata[38:34] == CNT_W'(MAX_STOPS))
  `CGR_ASSERT_IMP(a_err_no_color, out_tvalid && (out_tdata[33:32] != STATUS_OK), out_tdata[31:0] == '0)
  `CGR_ASSERT_IMP(a_add_room, cmd.add_wr, stat.total < CNT_W'(MAX_STOPS))

endmodule
